@@ rtl/pid_position_loop_with_settle_macros.svh @@
// Assertion macros for the position PID loop.
// Used by the top level; relies on the aclk / aresetn port names.
`ifndef PID_POSITION_LOOP_WITH_SETTLE_MACROS_SVH
`define PID_POSITION_LOOP_WITH_SETTLE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PIDPOS_CHECK_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PIDPOS_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pidpos_pkg.sv @@
// Shared types and constants for the position PID loop.
// No dependencies.
`timescale 1ns / 1ps

package pidpos_pkg;

    localparam int COUNT_W = 32;
    localparam int GAIN_W  = 32;
    localparam int PROD_W  = 64;
    localparam int TERM_W  = 16;
    localparam int DUTY_W  = 10;
    localparam int TOL_W   = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;

    typedef logic signed [COUNT_W-1:0] count_t;
    typedef logic signed [GAIN_W-1:0]  gain_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [TERM_W-1:0]  term_t;
    typedef logic        [DUTY_W-1:0]  duty_t;
    typedef logic        [TOL_W-1:0]   tol_t;

    localparam term_t TERM_MAX = 16'sh7FFF;
    localparam term_t TERM_MIN = -16'sh8000;

    // Register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_GAIN_P       = 3'd0,
        REG_GAIN_I       = 3'd1,
        REG_GAIN_D       = 3'd2,
        REG_DUTY_LIMIT   = 3'd3,
        REG_TOL_TURN     = 3'd4,
        REG_TOL_STRAIGHT = 3'd5
    } cfg_idx_t;

    localparam gain_t RST_GAIN_P       = 32'sd6553600;
    localparam gain_t RST_GAIN_I       = 32'sd7;
    localparam gain_t RST_GAIN_D       = 32'sd589824;
    localparam duty_t RST_DUTY_LIMIT   = 10'd1000;
    localparam tol_t  RST_TOL_TURN     = 16'd100;
    localparam tol_t  RST_TOL_STRAIGHT = 16'd40;

endpackage

@@ rtl/pidpos_term.sv @@
// One PID term: fixed-point product scaled down, truncated toward zero,
// saturated to 16 bits. Depends on pidpos_pkg.
`timescale 1ns / 1ps

module pidpos_term #(
    parameter int FRAC_BITS = 16
) (
    input  pidpos_pkg::prod_t product,
    output pidpos_pkg::term_t term
);
    import pidpos_pkg::*;

    localparam prod_t ROUND_ADJ = (PROD_W'(1) <<< FRAC_BITS) - PROD_W'(1);

    prod_t adj;
    prod_t scaled;

    // bias negatives up so the arithmetic shift truncates toward zero
    assign adj    = product + (product[PROD_W-1] ? ROUND_ADJ : '0);
    assign scaled = adj >>> FRAC_BITS;

    always_comb begin
        if (scaled > PROD_W'(TERM_MAX)) begin
            term = TERM_MAX;
        end else if (scaled < PROD_W'(TERM_MIN)) begin
            term = TERM_MIN;
        end else begin
            term = scaled[TERM_W-1:0];
        end
    end

endmodule

@@ rtl/pid_position_loop_with_settle.sv @@
// Position PID loop for one wheel with settle window, top level.
// Depends on pidpos_pkg, pidpos_term and the macros header.
`timescale 1ns / 1ps
`include "pid_position_loop_with_settle_macros.svh"

//  channel   | direction | tdata (low bit up)                      | tuser
//  ----------+-----------+-----------------------------------------+-------------------------
//  s_ (in)   | sink      | target_count[31:0], measured_count      | turn_mode
//  m_ (out)  | source    | drive_magnitude[9:0], zero pad to 16    | drive_forward, in_position
//  APB cfg   | sink      | 6 registers at 4*i, 32-bit data         | -
//
//  One transfer per cycle in, one per cycle out while m_tready is high. m_tvalid follows
//  the input transfer through the registers error/state, products, terms, sum/clamp.
//  Each of the four stages has its own valid and frees as soon as the next
//  stage can take its contents, so bubbles collapse and a stalled output
//  still lets earlier stages fill.
//  aresetn is synchronous: clears the error sum, last error, all valids and
//  loads the register defaults.

module pid_position_loop_with_settle #(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] target_count, [63:32] measured_count
    input  logic [0:0]  s_tuser,   // [0] turn_mode

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [9:0] drive_magnitude, [15:10] zero
    output logic [1:0]  m_tuser,   // [0] drive_forward, [1] in_position

    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pidpos_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [pidpos_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [pidpos_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                pready
);
    import pidpos_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    gain_t gain_p_reg;
    gain_t gain_i_reg;
    gain_t gain_d_reg;
    duty_t duty_limit_reg;
    tol_t  tol_turn_reg;
    tol_t  tol_straight_reg;

    logic     cfg_wr;
    cfg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = cfg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg       <= RST_GAIN_P;
            gain_i_reg       <= RST_GAIN_I;
            gain_d_reg       <= RST_GAIN_D;
            duty_limit_reg   <= RST_DUTY_LIMIT;
            tol_turn_reg     <= RST_TOL_TURN;
            tol_straight_reg <= RST_TOL_STRAIGHT;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_GAIN_P:       gain_p_reg       <= pwdata;
                REG_GAIN_I:       gain_i_reg       <= pwdata;
                REG_GAIN_D:       gain_d_reg       <= pwdata;
                REG_DUTY_LIMIT:   duty_limit_reg   <= pwdata[DUTY_W-1:0];
                REG_TOL_TURN:     tol_turn_reg     <= pwdata[TOL_W-1:0];
                REG_TOL_STRAIGHT: tol_straight_reg <= pwdata[TOL_W-1:0];
                default: ;  // unmapped: ignored
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_GAIN_P:       prdata = gain_p_reg;
            REG_GAIN_I:       prdata = gain_i_reg;
            REG_GAIN_D:       prdata = gain_d_reg;
            REG_DUTY_LIMIT:   prdata = CFG_DATA_W'(duty_limit_reg);
            REG_TOL_TURN:     prdata = CFG_DATA_W'(tol_turn_reg);
            REG_TOL_STRAIGHT: prdata = CFG_DATA_W'(tol_straight_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: each stage frees when empty or moving on
    // ------------------------------------------------------------------
    logic a_valid_reg, b_valid_reg, c_valid_reg, m_valid_reg;
    logic rdy_b, rdy_c, rdy_d;
    logic s_xfer;

    assign rdy_d    = !m_valid_reg || m_tready;
    assign rdy_c    = !c_valid_reg || rdy_d;
    assign rdy_b    = !b_valid_reg || rdy_c;
    assign s_tready = !a_valid_reg || rdy_b;
    assign s_xfer   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_tready) a_valid_reg <= s_tvalid;
            if (rdy_b)    b_valid_reg <= a_valid_reg;
            if (rdy_c)    c_valid_reg <= b_valid_reg;
            if (rdy_d)    m_valid_reg <= c_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: error, wrapping sum, difference, settle window.
    // error_sum_reg / last_error_reg double as the stage-A values of the
    // item held in A: they only change when A is refilled.
    // ------------------------------------------------------------------
    count_t error_sum_reg, error_sum_next;
    count_t last_error_reg;
    count_t err_in;
    count_t a_delta_reg;
    logic   a_inpos_reg;

    logic signed [COUNT_W:0] err_ext;
    logic signed [COUNT_W:0] tol_ext;
    logic                    inpos_in;

    assign err_in         = s_tdata[31:0] - s_tdata[63:32];
    assign error_sum_next = error_sum_reg + err_in;

    assign err_ext  = {err_in[COUNT_W-1], err_in};
    assign tol_ext  = (COUNT_W+1)'(s_tuser[0] ? tol_turn_reg : tol_straight_reg);
    // strictly inside: -tol < err < tol (empty window when tol is zero)
    assign inpos_in = (err_ext < tol_ext) && (err_ext > -tol_ext);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
        end else if (s_xfer) begin
            error_sum_reg  <= error_sum_next;
            last_error_reg <= err_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            a_delta_reg <= err_in - last_error_reg;
            a_inpos_reg <= inpos_in;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: the three gain products
    // ------------------------------------------------------------------
    prod_t b_prod_p_reg, b_prod_i_reg, b_prod_d_reg;
    logic  b_inpos_reg;

    always_ff @(posedge aclk) begin
        if (rdy_b && a_valid_reg) begin
            b_prod_p_reg <= PROD_W'(gain_p_reg) * PROD_W'(last_error_reg);
            b_prod_i_reg <= PROD_W'(gain_i_reg) * PROD_W'(error_sum_reg);
            b_prod_d_reg <= PROD_W'(gain_d_reg) * PROD_W'(a_delta_reg);
            b_inpos_reg  <= a_inpos_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: scale, truncate toward zero, saturate each term
    // ------------------------------------------------------------------
    term_t term_p, term_i, term_d;
    term_t c_term_p_reg, c_term_i_reg, c_term_d_reg;
    logic  c_inpos_reg;

    pidpos_term #(.FRAC_BITS(GAIN_FRAC_BITS)) u_term_p (
        .product (b_prod_p_reg),
        .term    (term_p)
    );

    pidpos_term #(.FRAC_BITS(GAIN_FRAC_BITS)) u_term_i (
        .product (b_prod_i_reg),
        .term    (term_i)
    );

    pidpos_term #(.FRAC_BITS(GAIN_FRAC_BITS)) u_term_d (
        .product (b_prod_d_reg),
        .term    (term_d)
    );

    always_ff @(posedge aclk) begin
        if (rdy_c && b_valid_reg) begin
            c_term_p_reg <= term_p;
            c_term_i_reg <= term_i;
            c_term_d_reg <= term_d;
            c_inpos_reg  <= b_inpos_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: sum, saturate, clamp to duty limit, zero when in position, split sign/magnitude
    // ------------------------------------------------------------------
    logic signed [TERM_W+1:0] sum_raw;
    term_t                    sum_sat;
    logic signed [DUTY_W+6:0] lim_ext;
    logic signed [DUTY_W+6:0] drive;
    logic signed [DUTY_W+6:0] drive_abs;
    duty_t                    mag_next;
    logic                     fwd_next;

    duty_t m_mag_reg;
    logic  m_fwd_reg;
    logic  m_inpos_reg;

    assign sum_raw = (TERM_W+2)'(c_term_p_reg) + (TERM_W+2)'(c_term_i_reg)
                   + (TERM_W+2)'(c_term_d_reg);

    always_comb begin
        if (sum_raw > (TERM_W+2)'(TERM_MAX)) begin
            sum_sat = TERM_MAX;
        end else if (sum_raw < (TERM_W+2)'(TERM_MIN)) begin
            sum_sat = TERM_MIN;
        end else begin
            sum_sat = sum_raw[TERM_W-1:0];
        end
    end

    assign lim_ext = $signed({7'b0, duty_limit_reg});

    always_comb begin
        drive = (DUTY_W+7)'(sum_sat);
        if (drive > lim_ext) begin
            drive = lim_ext;
        end else if (drive < -lim_ext) begin
            drive = -lim_ext;
        end
        drive_abs = drive[DUTY_W+6] ? -drive : drive;
        if (c_inpos_reg) begin
            mag_next = '0;
            fwd_next = 1'b0;
        end else begin
            mag_next = drive_abs[DUTY_W-1:0];
            // positive: sign clear and not zero
            fwd_next = !drive[DUTY_W+6] && (drive_abs != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_d && c_valid_reg) begin
            m_mag_reg   <= mag_next;
            m_fwd_reg   <= fwd_next;
            m_inpos_reg <= c_inpos_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_mag_reg};
    assign m_tuser  = {m_inpos_reg, m_fwd_reg};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `PIDPOS_CHECK_NOW(a_settled_no_drive, m_valid_reg && m_inpos_reg, m_mag_reg == '0 && !m_fwd_reg, "drive while in position")
    `PIDPOS_CHECK_NOW(a_mag_within_limit, m_valid_reg, m_mag_reg <= duty_limit_reg, "drive magnitude above duty limit")
    `PIDPOS_CHECK_NOW(a_fwd_nonzero, m_valid_reg && m_fwd_reg, m_mag_reg != '0, "forward flag with zero magnitude")
    `PIDPOS_CHECK_NEXT(a_state_on_xfer, !s_xfer, $stable(error_sum_reg) && $stable(last_error_reg), "loop state moved without a transfer")

endmodule
